[src/fbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbt_pkg
// Shared widths, register indexes and reset values of the flipbook tile
// selector.
// ----------------------------------------------------------------------------
package fbt_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int FRAME_W = 24;
  localparam int CYCLE_W = 16;
  localparam int IDX_W   = 24;
  localparam int UV_W    = 18;

  localparam int IN_DATA_W  = FRAME_W + CYCLE_W;
  localparam int OUT_DATA_W = IDX_W + 4 * UV_W;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE      = 3'd6;

  localparam int TEX_DIM_RST = 256;
  localparam int TILE_RST    = 16;
  localparam int STRIDE_RST  = 16;

endpackage

[src/flipbook_tile_uv_select_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flipbook_tile_uv_select_core
// Picks the atlas tile for a frame number and gives its UV rectangle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: frame, cycle_frames
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: tile_index, u_left,
//          |           |                    |   v_top, u_right, v_bottom
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle sustained while m_tready stays high and the grid size is
// not being recomputed. The pipe is built of bit-per-stage dividers: frame*tiles by
// cycle, the modulo by the tile count, the split by columns and the UV quotients.
// After reset and after every config write the column, row and tile counts are
// recomputed by a serial divider; s_tready stays low meanwhile.
// A stall on m_tready freezes the pipe; empty entry stage still takes input.
// Reset is synchronous, active high, clears valid bits and loads config reset values.
// ----------------------------------------------------------------------------
module flipbook_tile_uv_select_core #(
  parameter int COORD_BITS = fbt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = fbt_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // frame [23:0], cycle_frames [39:24]
  input  logic [fbt_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tile_index [23:0], u_left [41:24], v_top [59:42], u_right [77:60],
  // v_bottom [95:78]
  output logic [fbt_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]            cfg_data
);
  import fbt_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int TILE_W = 2 * C;
  localparam int PROD_W = FRAME_W + TILE_W;
  localparam int Q_W    = F + 2;
  localparam int CNT_W  = $clog2(C + 1);

  localparam int S_D2  = 1 + PROD_W;
  localparam int S_D3  = S_D2 + PROD_W;
  localparam int S_MUL = S_D3 + TILE_W + 1;
  localparam int S_TX  = S_MUL + 1;
  localparam int S_OUT = S_TX + Q_W + 1;

  // ---------------------------------------------------------------- config
  logic [C-1:0] tex_w, tex_h, tile_w, tile_h, str_w, str_h;
  logic         loop_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_w     <= C'(TEX_DIM_RST);
      tex_h     <= C'(TEX_DIM_RST);
      tile_w    <= C'(TILE_RST);
      tile_h    <= C'(TILE_RST);
      str_w     <= C'(STRIDE_RST);
      str_h     <= C'(STRIDE_RST);
      loop_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEXTURE_WIDTH:  tex_w     <= cfg_data;
        CFG_TEXTURE_HEIGHT: tex_h     <= cfg_data;
        CFG_TILE_WIDTH:     tile_w    <= cfg_data;
        CFG_TILE_HEIGHT:    tile_h    <= cfg_data;
        CFG_STRIDE_WIDTH:   str_w     <= cfg_data;
        CFG_STRIDE_HEIGHT:  str_h     <= cfg_data;
        CFG_LOOP_MODE:      loop_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------- grid size, serial divider
  typedef enum logic [2:0] {ST_LOAD, ST_DIV, ST_PROD, ST_TILES, ST_READY} calc_state_t;

  calc_state_t       st;
  logic [CNT_W-1:0]  cnt;
  logic [C-1:0]      tw_e, th_e, sw_e, sh_e;
  logic [C-1:0]      qx_rem, qx_w, qy_rem, qy_w;
  logic [C-1:0]      xt, yt;
  logic [TILE_W-1:0] tiles;
  logic [TILE_W-1:0] tiles_m1;
  logic [C:0]        qx_t, qy_t;
  logic              qx_ge, qy_ge;

  assign qx_t  = {qx_rem, qx_w[C-1]};
  assign qy_t  = {qy_rem, qy_w[C-1]};
  assign qx_ge = qx_t >= {1'b0, sw_e};
  assign qy_ge = qy_t >= {1'b0, sh_e};
  assign tiles_m1 = tiles - TILE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_LOAD;
      cnt <= '0;
    end else if (cfg_valid) begin
      st <= ST_LOAD;
    end else begin
      unique case (st)
        ST_LOAD: begin
          tw_e   <= (tex_w == '0) ? C'(1) : tex_w;
          th_e   <= (tex_h == '0) ? C'(1) : tex_h;
          sw_e   <= (str_w == '0) ? C'(1) : str_w;
          sh_e   <= (str_h == '0) ? C'(1) : str_h;
          qx_w   <= (tex_w == '0) ? C'(1) : tex_w;
          qy_w   <= (tex_h == '0) ? C'(1) : tex_h;
          qx_rem <= '0;
          qy_rem <= '0;
          cnt    <= '0;
          st     <= ST_DIV;
        end
        ST_DIV: begin
          qx_rem <= qx_ge ? C'(qx_t - {1'b0, sw_e}) : qx_t[C-1:0];
          qy_rem <= qy_ge ? C'(qy_t - {1'b0, sh_e}) : qy_t[C-1:0];
          qx_w   <= {qx_w[C-2:0], qx_ge};
          qy_w   <= {qy_w[C-2:0], qy_ge};
          cnt    <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(C - 1)) begin
            st <= ST_PROD;
          end
        end
        ST_PROD: begin
          xt <= (qx_w == '0) ? C'(1) : qx_w;
          yt <= (qy_w == '0) ? C'(1) : qy_w;
          st <= ST_TILES;
        end
        ST_TILES: begin
          tiles <= TILE_W'(xt) * TILE_W'(yt);
          st    <= ST_READY;
        end
        ST_READY: st <= ST_READY;
        default:  st <= ST_LOAD;
      endcase
    end
  end

  // -------------------------------------------------------- pipe control
  logic vld [0:S_OUT];
  logic en;

  assign en       = m_tready || !vld[S_OUT];
  assign s_tready = (st == ST_READY) && (en || !vld[0]);
  assign m_tvalid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= S_OUT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      if (en || !vld[0]) begin
        vld[0] <= s_tvalid && (st == ST_READY);
      end
      if (en) begin
        for (int i = 1; i <= S_OUT; i++) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // entry and product
  logic [FRAME_W-1:0] s0_frame;
  logic [CYCLE_W-1:0] s0_cyc;
  logic [PROD_W-1:0]  s1_prod;
  logic [CYCLE_W-1:0] s1_cyc;

  always_ff @(posedge clk) begin
    if (en || !vld[0]) begin
      s0_frame <= s_tdata[FRAME_W-1:0];
      s0_cyc   <= (s_tdata[IN_DATA_W-1:FRAME_W] == '0) ? CYCLE_W'(1)
                                                       : s_tdata[IN_DATA_W-1:FRAME_W];
    end
    if (en) begin
      s1_prod <= PROD_W'(s0_frame) * PROD_W'(tiles);
      s1_cyc  <= s0_cyc;
    end
  end

  // -------------------------------------- frame*tiles / cycle, bit a stage
  logic [CYCLE_W-1:0] d1_rem [0:PROD_W];
  logic [PROD_W-1:0]  d1_w   [0:PROD_W];
  logic [CYCLE_W-1:0] d1_d   [0:PROD_W];

  assign d1_rem[0] = '0;
  assign d1_w[0]   = s1_prod;
  assign d1_d[0]   = s1_cyc;

  for (genvar k = 0; k < PROD_W; k++) begin : g_d1
    logic [CYCLE_W:0] t;
    logic             ge;
    assign t  = {d1_rem[k], d1_w[k][PROD_W-1]};
    assign ge = t >= {1'b0, d1_d[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        d1_rem[k+1] <= ge ? CYCLE_W'(t - {1'b0, d1_d[k]}) : t[CYCLE_W-1:0];
        d1_w[k+1]   <= {d1_w[k][PROD_W-2:0], ge};
        d1_d[k+1]   <= d1_d[k];
      end
    end
  end

  // ------------------------------------------------ index modulo tiles
  logic [TILE_W-1:0] d2_rem [0:PROD_W];
  logic [PROD_W-1:0] d2_w   [0:PROD_W];
  logic              d2_big [0:PROD_W];
  logic [TILE_W-1:0] d2_lo  [0:PROD_W];

  assign d2_rem[0] = '0;
  assign d2_w[0]   = d1_w[PROD_W];
  assign d2_big[0] = d1_w[PROD_W] >= PROD_W'(tiles);
  assign d2_lo[0]  = d1_w[PROD_W][TILE_W-1:0];

  for (genvar k = 0; k < PROD_W; k++) begin : g_d2
    logic [TILE_W:0] t;
    logic            ge;
    assign t  = {d2_rem[k], d2_w[k][PROD_W-1]};
    assign ge = t >= {1'b0, tiles};
    always_ff @(posedge clk) begin
      if (en) begin
        d2_rem[k+1] <= ge ? TILE_W'(t - {1'b0, tiles}) : t[TILE_W-1:0];
        d2_w[k+1]   <= {d2_w[k][PROD_W-2:0], 1'b0};
        d2_big[k+1] <= d2_big[k];
        d2_lo[k+1]  <= d2_lo[k];
      end
    end
  end

  logic [TILE_W-1:0] idx_sel;
  assign idx_sel = !d2_big[PROD_W] ? d2_lo[PROD_W] :
                   (loop_mode ? d2_rem[PROD_W] : tiles_m1);

  // --------------------------------------------- column and row split
  logic [C-1:0]      d3_rem [0:TILE_W];
  logic [TILE_W-1:0] d3_w   [0:TILE_W];
  logic [IDX_W-1:0]  d3_idx [0:TILE_W];

  assign d3_rem[0] = '0;
  assign d3_w[0]   = idx_sel;
  assign d3_idx[0] = IDX_W'(idx_sel);

  for (genvar k = 0; k < TILE_W; k++) begin : g_d3
    logic [C:0] t;
    logic       ge;
    assign t  = {d3_rem[k], d3_w[k][TILE_W-1]};
    assign ge = t >= {1'b0, xt};
    always_ff @(posedge clk) begin
      if (en) begin
        d3_rem[k+1] <= ge ? C'(t - {1'b0, xt}) : t[C-1:0];
        d3_w[k+1]   <= {d3_w[k][TILE_W-2:0], ge};
        d3_idx[k+1] <= d3_idx[k];
      end
    end
  end

  // rows counted from the bottom of the grid
  logic [C-1:0] row;
  assign row = yt - C'(1) - d3_w[TILE_W][C-1:0];

  logic [TILE_W-1:0] m_px, m_py;
  logic [IDX_W-1:0]  m_idx;

  always_ff @(posedge clk) begin
    if (en) begin
      m_px  <= TILE_W'(sw_e) * TILE_W'(d3_rem[TILE_W]);
      m_py  <= TILE_W'(sh_e) * TILE_W'(row);
      m_idx <= d3_idx[TILE_W];
    end
  end

  // ---------------------------------------------------------- UV lanes
  logic [C-1:0]      lane_dim [0:3];
  logic [TILE_W:0]   lane_tex [0:3];
  logic [C+1:0]      tx_t     [0:3];
  logic              tx_sat   [0:3];
  logic [IDX_W-1:0]  tx_idx;

  always_comb begin
    lane_dim[0] = tw_e;
    lane_dim[1] = th_e;
    lane_dim[2] = tw_e;
    lane_dim[3] = th_e;
    lane_tex[0] = {1'b0, m_px};
    lane_tex[1] = {1'b0, m_py};
    lane_tex[2] = {1'b0, m_px} + (TILE_W + 1)'(tile_w);
    lane_tex[3] = {1'b0, m_py} + (TILE_W + 1)'(tile_h);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        tx_t[l]   <= lane_tex[l][C+1:0];
        // quotient reaches 4.0 or more
        tx_sat[l] <= lane_tex[l] >= (TILE_W + 1)'({lane_dim[l], 2'b00});
      end
      tx_idx <= m_idx;
    end
  end

  logic [C-1:0]     uv_rem [0:3][0:Q_W];
  logic [Q_W-1:0]   uv_w   [0:3][0:Q_W];
  logic             uv_sat [0:3][0:Q_W];
  logic [IDX_W-1:0] uv_idx [0:Q_W];

  assign uv_idx[0] = tx_idx;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign uv_rem[l][0] = tx_t[l][C+1:2];
    assign uv_w[l][0]   = {tx_t[l][1:0], {F{1'b0}}};
    assign uv_sat[l][0] = tx_sat[l];
    for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [C:0] t;
      logic       ge;
      assign t  = {uv_rem[l][k], uv_w[l][k][Q_W-1]};
      assign ge = t >= {1'b0, lane_dim[l]};
      always_ff @(posedge clk) begin
        if (en) begin
          uv_rem[l][k+1] <= ge ? C'(t - {1'b0, lane_dim[l]}) : t[C-1:0];
          uv_w[l][k+1]   <= {uv_w[l][k][Q_W-2:0], ge};
          uv_sat[l][k+1] <= uv_sat[l][k];
        end
      end
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_uv_idx
    always_ff @(posedge clk) begin
      if (en) begin
        uv_idx[k+1] <= uv_idx[k];
      end
    end
  end

  logic [Q_W+UV_W-1:0] uv_ext [0:3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      uv_ext[l] = {{UV_W{1'b0}}, (uv_sat[l][Q_W] ? {Q_W{1'b1}} : uv_w[l][Q_W])};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {uv_ext[3][UV_W-1:0], uv_ext[2][UV_W-1:0], uv_ext[1][UV_W-1:0],
                  uv_ext[0][UV_W-1:0], uv_idx[Q_W]};
    end
  end

  // ---------------------------------------------------------- assertions
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> !s_tready)
    else $error("input taken while grid size is being recomputed");

  a_tiles_nonzero: assert property (@(posedge clk) disable iff (rst)
    st == ST_READY |-> tiles != '0)
    else $error("tile count is zero");

  a_cols_fit: assert property (@(posedge clk) disable iff (rst)
    st == ST_READY |-> (TILE_W'(xt) * TILE_W'(sw_e) <= TILE_W'(tw_e)) || (xt == C'(1)))
    else $error("column count exceeds texture width over stride");

  a_rows_fit: assert property (@(posedge clk) disable iff (rst)
    st == ST_READY |-> (TILE_W'(yt) * TILE_W'(sh_e) <= TILE_W'(th_e)) || (yt == C'(1)))
    else $error("row count exceeds texture height over stride");

endmodule
